>>> src/assert_macros.svh
// assertion macros used by the sampler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// condition implies consequence in the next cycle
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> src/wis_pkg.sv
// package of the weighted index sampler: sizes, codes and payload types
package wis_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int SUM_W       = IDX_W + 32;
    localparam int SAMPLE_W    = 10;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic        start_table;
        logic [31:0] weight;
        logic [31:0] uniform;
    } wis_in_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_index;
        logic                empty_or_zero;
    } wis_out_t;

endpackage

>>> src/weighted_index_sampler_unit.sv
// weighted index sampler: cumulative weight table and inverse-cdf draws
//
// input channel s_valid/s_ready/s_data carries one request: a load appends
// a weight to the cumulative table (start_table begins a new table), a draw
// picks an entry by comparing the table against floor(uniform * total / 2^32).
// result channel m_valid/m_ready/m_data carries one result per draw and none
// per load; loads beyond the table depth are dropped.
// a load writes its entry when it is accepted. a draw runs a low multiply,
// a high multiply and a sum step on 32-bit multiplies, then a binary search
// in which the single read port of the cumulative memory gives one probe
// per cycle, on a table of up to 1024 entries. a draw on an empty table
// or a zero total skips these steps and goes straight to its result.
// one request is at work at a time; s_ready is high while idle.
// the result waits in an output register; while the receiver stalls, loads
// are still taken, and a finished draw holds until the register frees.
// reset (aresetn low, synchronous) empties the table and the output; the
// memory is not cleared, only entries below the entry count are read.
module weighted_index_sampler_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  wis_pkg::wis_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output wis_pkg::wis_out_t m_data
);
    import wis_pkg::*;

`include "assert_macros.svh"

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL_LO = 3'd1;
    localparam logic [2:0] ST_MUL_HI = 3'd2;
    localparam logic [2:0] ST_SUM    = 3'd3;
    localparam logic [2:0] ST_SEARCH = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [SUM_W-1:0] mem [MAX_ENTRIES];
    logic [SUM_W-1:0] rdata_reg;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0] total_reg, total_next;
    logic [31:0]      u_reg, u_next;
    logic [63:0]      prod_reg, prod_next;
    logic [31:0]      carry_reg, carry_next;
    logic [SUM_W-1:0] thr_reg, thr_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [IDX_W-1:0] mid_reg, mid_next;
    logic             pend_reg, pend_next;
    wis_out_t         result_reg, result_next;
    logic             m_valid_reg, m_valid_next;
    wis_out_t         m_data_reg, m_data_next;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [SUM_W-1:0] mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;

    logic             cmp_gt;
    logic [CNT_W-1:0] load_cnt;
    logic [SUM_W-1:0] load_tot;
    logic [SUM_W-1:0] load_sum;
    logic [CNT_W-1:0] srch_lo;
    logic [CNT_W-1:0] srch_hi;
    logic [CNT_W-1:0] srch_mid;
    logic [CNT_W-1:0] pick;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_comb begin
        cmp_gt   = rdata_reg > thr_reg;
        load_cnt = s_data.start_table ? '0 : cnt_reg;
        load_tot = s_data.start_table ? '0 : total_reg;
        load_sum = load_tot + SUM_W'(s_data.weight);

        srch_lo = lo_reg;
        srch_hi = hi_reg;
        if (pend_reg) begin
            if (cmp_gt) begin
                srch_hi = CNT_W'(mid_reg);
            end else begin
                srch_lo = CNT_W'(mid_reg) + CNT_W'(1);
            end
        end
        srch_mid = srch_lo + ((srch_hi - srch_lo) >> 1);
        pick     = (srch_lo < cnt_reg) ? srch_lo : cnt_reg - CNT_W'(1);

        state_next   = state_reg;
        cnt_next     = cnt_reg;
        total_next   = total_reg;
        u_next       = u_reg;
        prod_next    = prod_reg;
        carry_next   = carry_reg;
        thr_next     = thr_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        pend_next    = pend_reg;
        result_next  = result_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        mem_we    = 1'b0;
        mem_waddr = load_cnt[IDX_W-1:0];
        mem_wdata = load_sum;
        mem_re    = 1'b0;
        mem_raddr = srch_mid[IDX_W-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.cmd == CMD_LOAD) begin
                        if (load_cnt < CNT_W'(MAX_ENTRIES)) begin
                            mem_we     = 1'b1;
                            cnt_next   = load_cnt + CNT_W'(1);
                            total_next = load_sum;
                        end else begin
                            cnt_next   = load_cnt;
                            total_next = load_tot;
                        end
                    end else begin
                        u_next = s_data.uniform;
                        if (cnt_reg == '0 || total_reg == '0) begin
                            result_next.sample_index  = '0;
                            result_next.empty_or_zero = 1'b1;
                            state_next                = ST_FINISH;
                        end else begin
                            state_next = ST_MUL_LO;
                        end
                    end
                end
            end
            ST_MUL_LO: begin
                prod_next  = 64'(u_reg) * 64'(total_reg[31:0]);
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                carry_next = prod_reg[63:32];
                prod_next  = 64'(u_reg) * 64'(total_reg >> 32);
                state_next = ST_SUM;
            end
            ST_SUM: begin
                thr_next   = SUM_W'(prod_reg) + SUM_W'(carry_reg);
                lo_next    = '0;
                hi_next    = cnt_reg;
                pend_next  = 1'b0;
                state_next = ST_SEARCH;
            end
            ST_SEARCH: begin
                lo_next = srch_lo;
                hi_next = srch_hi;
                if (srch_lo < srch_hi) begin
                    mem_re    = 1'b1;
                    mid_next  = srch_mid[IDX_W-1:0];
                    pend_next = 1'b1;
                end else begin
                    pend_next                 = 1'b0;
                    result_next.sample_index  = SAMPLE_W'(pick);
                    result_next.empty_or_zero = 1'b0;
                    state_next                = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = result_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            total_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            total_reg   <= total_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        u_reg      <= u_next;
        prod_reg   <= prod_next;
        carry_reg  <= carry_next;
        thr_reg    <= thr_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        result_reg <= result_next;
        m_data_reg <= m_data_next;
    end

    // probes stay inside the written part of the table
    `ASSERT_IMPLIES(a_probe_in_table, aclk, aresetn,
        (state_reg == ST_SEARCH) && pend_reg, CNT_W'(mid_reg) < cnt_reg)

    // the scaled threshold stays below the total
    `ASSERT_IMPLIES(a_thr_below_total, aclk, aresetn,
        state_reg == ST_SEARCH, thr_reg < total_reg)

    // entry count never passes the depth
    `ASSERT_IMPLIES(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= CNT_W'(MAX_ENTRIES))

    // a flagged result always carries index zero
    `ASSERT_IMPLIES(a_flag_index_zero, aclk, aresetn,
        m_valid_reg && m_data_reg.empty_or_zero, m_data_reg.sample_index == '0)

    // the table does not change during the search of a draw
    `ASSERT_NEXT(a_table_frozen, aclk, aresetn,
        (state_reg == ST_SEARCH) && (state_next == ST_SEARCH),
        $stable(cnt_reg) && $stable(total_reg))

endmodule
